### rtl/csp_pkg.sv
// Shared constants for the counting semaphore pool.
package csp_pkg;

  // Default sizes of the pool.
  localparam int DEF_NUM_SEMAPHORES = 256;
  localparam int DEF_COUNT_WIDTH    = 16;

  // Fixed widths of the request and result words.
  localparam int MODE_W   = 2;
  localparam int ARG_W    = 16;
  localparam int HANDLE_W = 8;

  // Entries checked per cycle by the free-entry scan.
  localparam int SCAN_CHUNK = 8;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_P      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_V      = 2'd2;

  // Result status codes.
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

endpackage

### rtl/csp_if.sv
// Request and result channel interfaces of the semaphore pool.
interface csp_in_if;
  logic                              valid;
  logic                              ready;
  logic [csp_pkg::MODE_W-1:0]        mode;
  logic signed [csp_pkg::ARG_W-1:0]  argument;

  modport source (output valid, output mode, output argument, input ready);
  modport sink   (input valid, input mode, input argument, output ready);
endinterface

interface csp_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [csp_pkg::HANDLE_W-1:0]   sem_handle;
  logic                           must_wait;
  logic                           wake_one;

  modport source (output valid, output status, output sem_handle, output must_wait,
                  output wake_one, input ready);
  modport sink   (input valid, input status, input sem_handle, input must_wait,
                  input wake_one, output ready);
endinterface

### rtl/csp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/csp_scan.sv
// Round-robin window scan over the allocation flags: first free entry from pos.
module csp_scan #(
  parameter int NUM = 256,
  parameter int WIN = 8
) (
  input  logic [NUM-1:0]         alloc,
  input  logic [$clog2(NUM)-1:0] pos,
  output logic                   found,
  output logic [$clog2(NUM)-1:0] hit,
  output logic [$clog2(NUM)-1:0] pos_next
);

  localparam int IDW = $clog2(NUM);
  localparam int SW  = IDW + 1;

  always_comb begin
    logic [SW-1:0]  sum;
    logic [SW-1:0]  nsum;
    logic [IDW-1:0] idx;
    found = 1'b0;
    hit   = '0;
    sum   = '0;
    idx   = '0;
    // walk the window from its far end so the nearest free entry wins
    for (int k = WIN - 1; k >= 0; k--) begin
      sum = SW'(pos) + SW'(k);
      if (sum >= SW'(NUM)) begin
        sum = sum - SW'(NUM);
      end
      idx = sum[IDW-1:0];
      if (!alloc[idx]) begin
        found = 1'b1;
        hit   = idx;
      end
    end
    nsum = SW'(pos) + SW'(WIN);
    if (nsum >= SW'(NUM)) begin
      nsum = nsum - SW'(NUM);
    end
    pos_next = nsum[IDW-1:0];
  end

endmodule

### rtl/counting_semaphore_pool.sv
// Counting semaphore pool: create, P and V requests against a table of semaphores.
//
// The pool holds NUM_SEMAPHORES counting semaphores. Each entry's count and
// waiter count live in one RAM word with a registered read; the allocation
// flags are flip-flops cleared by reset. One request is handled at a time.
// P and V go through RAM read at acceptance, modify and write back, then the
// result register. A create scans the allocation flags SCAN_CHUNK entries
// per cycle, round-robin from the search pointer; with few entries in use
// the first window already holds a free entry. Requests that fail (bad id,
// negative initial count, full pool, unused mode) go straight to the result
// register and leave the state alone. A new request is taken while the
// previous result still waits in the output register. Counts and waiter
// counts saturate at 2^COUNT_WIDTH-1; entries are never freed.
module counting_semaphore_pool #(
  parameter int NUM_SEMAPHORES = csp_pkg::DEF_NUM_SEMAPHORES,
  parameter int COUNT_WIDTH    = csp_pkg::DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  csp_in_if.sink    in_chan,
  csp_out_if.source out_chan
);

  localparam int IDW  = $clog2(NUM_SEMAPHORES);
  localparam int ACW  = $clog2(NUM_SEMAPHORES + 1);
  localparam int WIN  = (NUM_SEMAPHORES < csp_pkg::SCAN_CHUNK) ?
                        NUM_SEMAPHORES : csp_pkg::SCAN_CHUNK;
  localparam int RAMW = 2 * COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic                           status;
    logic [csp_pkg::HANDLE_W-1:0]   sem_handle;
    logic                           must_wait;
    logic                           wake_one;
  } res_t;

  localparam res_t RES_ERR = '{status: csp_pkg::ST_ERR, sem_handle: '0,
                               must_wait: 1'b0, wake_one: 1'b0};

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MOD, S_RESP} state_t;

  state_t                         state_r, state_nxt;
  logic [csp_pkg::MODE_W-1:0]     op_mode_r, op_mode_nxt;
  logic [csp_pkg::ARG_W-1:0]      op_arg_r, op_arg_nxt;
  logic [IDW-1:0]                 pos_r, pos_nxt;
  logic [IDW-1:0]                 start_r, start_nxt;
  logic [NUM_SEMAPHORES-1:0]      alloc_r, alloc_nxt;
  logic [ACW-1:0]                 alloc_cnt_r, alloc_cnt_nxt;
  res_t                           res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  res_t                           out_res_r, out_res_nxt;

  logic                           in_acc;
  logic [csp_pkg::ARG_W-1:0]      arg_u;
  logic                           id_ok;
  logic                           pool_full;
  logic                           slot_free;

  logic                           ram_we;
  logic [IDW-1:0]                 ram_waddr;
  logic [RAMW-1:0]                ram_wdata;
  logic [RAMW-1:0]                ram_rdata;

  logic                           scan_found;
  logic [IDW-1:0]                 scan_hit;
  logic [IDW-1:0]                 scan_next;

  logic [COUNT_WIDTH-1:0]         cur_cnt;
  logic [COUNT_WIDTH-1:0]         cur_wt;
  logic [31:0]                    init_wide;
  logic [COUNT_WIDTH-1:0]         init_cnt;

  // count and waiter count of each semaphore, {count, waiters}
  csp_ram #(
    .WIDTH (RAMW),
    .DEPTH (NUM_SEMAPHORES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_chan.argument[IDW-1:0]),
    .rdata (ram_rdata)
  );

  csp_scan #(
    .NUM (NUM_SEMAPHORES),
    .WIN (WIN)
  ) u_scan (
    .alloc    (alloc_r),
    .pos      (pos_r),
    .found    (scan_found),
    .hit      (scan_hit),
    .pos_next (scan_next)
  );

  assign in_chan.ready       = (state_r == S_IDLE);
  assign in_acc              = in_chan.valid && in_chan.ready;
  assign arg_u               = in_chan.argument;
  assign pool_full           = (alloc_cnt_r == ACW'(NUM_SEMAPHORES));
  assign slot_free           = !out_valid_r || out_chan.ready;

  // a valid id is non-negative, in range and allocated
  assign id_ok = !arg_u[csp_pkg::ARG_W-1] &&
                 (arg_u < csp_pkg::ARG_W'(NUM_SEMAPHORES)) &&
                 alloc_r[arg_u[IDW-1:0]];

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_res_r.status;
  assign out_chan.sem_handle = out_res_r.sem_handle;
  assign out_chan.must_wait  = out_res_r.must_wait;
  assign out_chan.wake_one   = out_res_r.wake_one;

  assign cur_cnt = ram_rdata[RAMW-1:COUNT_WIDTH];
  assign cur_wt  = ram_rdata[COUNT_WIDTH-1:0];

  // clamp the initial count into the count range
  assign init_wide = 32'(op_arg_r[csp_pkg::ARG_W-2:0]);
  assign init_cnt  = (init_wide > 32'(CNT_MAX)) ? CNT_MAX : init_wide[COUNT_WIDTH-1:0];

  always_comb begin
    state_nxt     = state_r;
    op_mode_nxt   = op_mode_r;
    op_arg_nxt    = op_arg_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    alloc_nxt     = alloc_r;
    alloc_cnt_nxt = alloc_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = op_arg_r[IDW-1:0];
    ram_wdata     = {cur_cnt, cur_wt};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_mode_nxt = in_chan.mode;
          op_arg_nxt  = arg_u;
          res_nxt     = RES_ERR;
          state_nxt   = S_RESP;
          case (in_chan.mode)
            csp_pkg::MODE_CREATE: begin
              // negative count or full pool: allocate nothing
              if (!arg_u[csp_pkg::ARG_W-1] && !pool_full) begin
                pos_nxt   = start_r;
                state_nxt = S_SCAN;
              end
            end
            csp_pkg::MODE_P, csp_pkg::MODE_V: begin
              // RAM read of the entry is already under way
              if (id_ok) begin
                state_nxt = S_MOD;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_found) begin
          ram_we              = 1'b1;
          ram_waddr           = scan_hit;
          ram_wdata           = {init_cnt, {COUNT_WIDTH{1'b0}}};
          alloc_nxt[scan_hit] = 1'b1;
          alloc_cnt_nxt       = alloc_cnt_r + ACW'(1);
          start_nxt           = (start_r == IDW'(NUM_SEMAPHORES - 1)) ?
                                '0 : start_r + IDW'(1);
          res_nxt.status      = csp_pkg::ST_OK;
          res_nxt.sem_handle  = csp_pkg::HANDLE_W'({{csp_pkg::HANDLE_W{1'b0}}, scan_hit});
          state_nxt           = S_RESP;
        end else begin
          pos_nxt = scan_next;
        end
      end

      S_MOD: begin
        ram_we         = 1'b1;
        res_nxt.status = csp_pkg::ST_OK;
        if (op_mode_r == csp_pkg::MODE_P) begin
          if (cur_cnt != '0) begin
            ram_wdata = {cur_cnt - COUNT_WIDTH'(1), cur_wt};
          end else begin
            // queue a waiter, saturating
            ram_wdata         = {cur_cnt, (cur_wt == CNT_MAX) ? cur_wt :
                                          cur_wt + COUNT_WIDTH'(1)};
            res_nxt.must_wait = 1'b1;
          end
        end else begin
          if (cur_wt != '0) begin
            // the released waiter takes the increment
            ram_wdata        = {cur_cnt, cur_wt - COUNT_WIDTH'(1)};
            res_nxt.wake_one = 1'b1;
          end else begin
            ram_wdata = {(cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1),
                         cur_wt};
          end
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // hold the result until the output register frees up
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= '0;
      alloc_r     <= '0;
      alloc_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      alloc_r     <= alloc_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_mode_r <= op_mode_nxt;
    op_arg_r  <= op_arg_nxt;
    pos_r     <= pos_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

### rtl/csp_chk.sv
// Port-level assertions for the semaphore pool, bound to its top level.
module csp_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic [csp_pkg::HANDLE_W-1:0] out_sem_handle,
  input logic                         out_must_wait,
  input logic                         out_wake_one
);

  logic [1:0] pending_r, pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // track words taken in but not yet delivered
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = pending_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == csp_pkg::ST_ERR) |->
      (out_sem_handle == '0) && !out_must_wait && !out_wake_one)
    else $error("error word carries nonzero fields");

  a_wait_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_must_wait || out_wake_one) |->
      (out_status == csp_pkg::ST_OK) && !(out_must_wait && out_wake_one) &&
      (out_sem_handle == '0))
    else $error("wait/wake flags inconsistent");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 2'd0))
    else $error("result word without a pending request");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (pending_r != 2'd3))
    else $error("more than two requests in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_sem_handle) &&
      $stable(out_must_wait) && $stable(out_wake_one))
    else $error("stalled result word changed");

endmodule

bind counting_semaphore_pool csp_chk u_csp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_sem_handle (out_chan.sem_handle),
  .out_must_wait  (out_chan.must_wait),
  .out_wake_one   (out_chan.wake_one)
);

### verif/tb_counting_semaphore_pool.sv
// Self-checking testbench for the counting semaphore pool: request driver, result monitor.
`timescale 1ns / 1ps

module tb_counting_semaphore_pool;
  import csp_pkg::*;

  localparam int NUM_SEM = DEF_NUM_SEMAPHORES;
  localparam int CNT_W   = DEF_COUNT_WIDTH;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Mode three has no meaning in the block; it must be rejected.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 1750;
  localparam int IDLE_PCT     = 27;
  localparam int REPORT_MAX   = 10;
  // Sized from the longest create scan, with some slack for the drain.
  localparam int DRAIN_CYCLES = 2 * (NUM_SEM / SCAN_CHUNK) + 20;
  // About 1.8k words, each bounded by the longest create scan plus random gaps on
  // both sides: a correct run stays well under this limit.
  localparam int CYCLE_LIMIT  = 400_000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ARG_W-1:0]  argument;
  } sem_req_t;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] sem_handle;
    logic                must_wait;
    logic                wake_one;
  } sem_outcome_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  csp_in_if  in_if ();
  csp_out_if out_if ();

  counting_semaphore_pool dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Driven side of both channels, known from time zero.
  logic     drv_valid = 1'b0;
  sem_req_t drv_word  = '0;
  logic     snk_ready = 1'b0;

  assign in_if.valid    = drv_valid;
  assign in_if.mode     = drv_word.mode;
  assign in_if.argument = drv_word.argument;
  assign out_if.ready   = snk_ready;

  // Shadow of the pool: allocation flags, counts, waiter counts, scan pointer.
  logic             slot_taken   [NUM_SEM];
  logic [CNT_W-1:0] slot_count   [NUM_SEM];
  logic [CNT_W-1:0] slot_waiters [NUM_SEM];
  int               scan_ptr;

  sem_req_t     req_backlog[$];
  sem_outcome_t owed_outcomes[$];

  int words_sent   = 0;
  int words_seen   = 0;
  int faults       = 0;
  int cycle_count  = 0;
  int gen_live     = 0;   // entries the stimulus knows are allocated: ids 0..gen_live-1
  int calm_lo      = 0;
  int calm_hi      = 0;

  int created_total  = 0;
  int blocked_total  = 0;
  int woken_total    = 0;
  int rejected_total = 0;
  int count_pinned   = 0;
  int waiters_pinned = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the shadow pool and return the result word it owes.
  function automatic sem_outcome_t apply_request(sem_req_t req);
    sem_outcome_t res;
    int           arg;
    int           pos;
    int           n;
    bit           found;
    res   = '{status: ST_ERR, sem_handle: '0, must_wait: 1'b0, wake_one: 1'b0};
    arg   = $signed(req.argument);
    found = 1'b0;
    pos   = 0;
    case (req.mode)
      MODE_CREATE: begin
        if (arg >= 0) begin
          for (n = 0; n < NUM_SEM; n++) begin
            if (!found && !slot_taken[(scan_ptr + n) % NUM_SEM]) begin
              found = 1'b1;
              pos   = (scan_ptr + n) % NUM_SEM;
            end
          end
          if (found) begin
            slot_taken[pos]   = 1'b1;
            slot_count[pos]   = (arg > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(arg);
            slot_waiters[pos] = '0;
            scan_ptr          = (scan_ptr + 1) % NUM_SEM;
            res.status        = ST_OK;
            res.sem_handle    = HANDLE_W'(pos);
            created_total++;
          end
        end
      end
      MODE_P: begin
        if (arg >= 0 && arg < NUM_SEM && slot_taken[arg]) begin
          res.status = ST_OK;
          if (slot_count[arg] != '0) begin
            slot_count[arg] = slot_count[arg] - 1'b1;
          end else begin
            // Count empty: queue the caller, waiter count sticks at its maximum.
            if (slot_waiters[arg] != CNT_MAX) begin
              slot_waiters[arg] = slot_waiters[arg] + 1'b1;
            end else begin
              waiters_pinned++;
            end
            res.must_wait = 1'b1;
            blocked_total++;
          end
        end
      end
      MODE_V: begin
        if (arg >= 0 && arg < NUM_SEM && slot_taken[arg]) begin
          res.status = ST_OK;
          if (slot_waiters[arg] != '0) begin
            // The woken waiter eats the increment.
            slot_waiters[arg] = slot_waiters[arg] - 1'b1;
            res.wake_one      = 1'b1;
            woken_total++;
          end else if (slot_count[arg] != CNT_MAX) begin
            slot_count[arg] = slot_count[arg] + 1'b1;
          end else begin
            count_pinned++;
          end
        end
      end
      default: ;
    endcase
    if (res.status == ST_ERR) rejected_total++;
    return res;
  endfunction

  // Random idling on either side, except inside the calm window.
  function automatic bit take_break();
    return !(words_sent >= calm_lo && words_sent < calm_hi) &&
           $urandom_range(99) < IDLE_PCT;
  endfunction

  task automatic push_word(input logic [MODE_W-1:0] mode, input int arg);
    sem_req_t w;
    w.mode     = mode;
    w.argument = ARG_W'(arg);
    req_backlog.push_back(w);
    // Entries are never freed and the pointer steps by one, so successes fill 0, 1, 2, ...
    if (mode == MODE_CREATE && arg >= 0 && gen_live < NUM_SEM) gen_live++;
  endtask

  // Pick an allocated id, leaning toward the most recent ones.
  function automatic int pick_live_id();
    if (gen_live > 8 && $urandom_range(1) == 1) return gen_live - 1 - $urandom_range(7);
    return $urandom_range(gen_live - 1);
  endfunction

  // Initial counts: mostly tiny so that P runs dry, plus extremes and junk.
  function automatic int create_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(4);
      6:                return $urandom_range(32767);
      7:                return ($urandom_range(1) == 1) ? 32767 : 0;
      8:                return -int'($urandom_range(32768, 1));
      default:          return int'($signed(ARG_W'($urandom())));
    endcase
  endfunction

  // Driver: count the word taken at this edge, then present the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        owed_outcomes.push_back(apply_request(drv_word));
        words_sent++;
      end
      if (!drv_valid || in_if.ready) begin
        if (req_backlog.size() != 0 && !take_break()) begin
          drv_word  <= req_backlog.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every result word taken at this edge against the oldest owed one.
  always @(posedge clk) begin : result_check
    sem_outcome_t seen;
    sem_outcome_t want;
    if (!rst_n) begin
      snk_ready <= 1'b0;
    end else begin
      if (out_if.valid && snk_ready) begin
        seen = '{status: out_if.status, sem_handle: out_if.sem_handle,
                 must_wait: out_if.must_wait, wake_one: out_if.wake_one};
        words_seen++;
        if (owed_outcomes.size() == 0) begin
          if (faults < REPORT_MAX) begin
            $display("[%0t] result word with nothing outstanding:", $realtime);
            $display("[%0t]   status=%0d handle=%0d wait=%0d wake=%0d",
                     $realtime, seen.status, seen.sem_handle, seen.must_wait, seen.wake_one);
          end
          faults++;
        end else begin
          want = owed_outcomes.pop_front();
          if (seen.status !== want.status || seen.sem_handle !== want.sem_handle ||
              seen.must_wait !== want.must_wait || seen.wake_one !== want.wake_one) begin
            if (faults < REPORT_MAX) begin
              $display("[%0t] result word %0d: expected status=%0d handle=%0d wait=%0d wake=%0d",
                       $realtime, words_seen, want.status, want.sem_handle, want.must_wait,
                       want.wake_one);
              $display("[%0t]   actual   status=%0d handle=%0d wait=%0d wake=%0d",
                       $realtime, seen.status, seen.sem_handle, seen.must_wait, seen.wake_one);
            end
            faults++;
          end
        end
      end
      snk_ready <= !take_break();
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words sent, %0d results outstanding.",
               cycle_count, words_sent, owed_outcomes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    int pick;
    logic [MODE_W-1:0] op;

    for (k = 0; k < NUM_SEM; k++) begin
      slot_taken[k]   = 1'b0;
      slot_count[k]   = '0;
      slot_waiters[k] = '0;
    end
    scan_ptr = 0;

    // Directed: errors on an empty pool, negative counts, wait and wake, bad ids.
    push_word(MODE_P, 0);
    push_word(MODE_V, 0);
    push_word(MODE_CREATE, -5);
    push_word(MODE_CREATE, -32768);
    push_word(MODE_CREATE, 0);        // id 0
    push_word(MODE_CREATE, 32767);    // id 1
    push_word(MODE_CREATE, 1);        // id 2
    push_word(MODE_P, 0);             // count empty: block
    push_word(MODE_P, 0);
    push_word(MODE_V, 0);             // wake
    push_word(MODE_V, 0);
    push_word(MODE_V, 0);             // no waiters left: count goes up
    push_word(MODE_P, 2);
    push_word(MODE_P, 2);
    push_word(MODE_P, -1);
    push_word(MODE_V, 32767);
    push_word(MODE_P, NUM_SEM);
    push_word(MODE_V, -32768);
    push_word(MODE_UNUSED, 0);
    push_word(MODE_UNUSED, -1);
    push_word(MODE_V, NUM_SEM - 1);   // never allocated yet
    push_word(MODE_P, 1);

    // Large initial count stepped both ways, then a waiter queue built and drained.
    push_word(MODE_CREATE, 32767);    // id 3
    for (k = 0; k < 4; k++) push_word(MODE_V, 3);
    push_word(MODE_P, 3);
    push_word(MODE_CREATE, 0);        // id 4
    for (k = 0; k < 6; k++) push_word(MODE_P, 4);
    for (k = 0; k < 7; k++) push_word(MODE_V, 4);

    // Random: mostly well-formed P/V on live ids, creates that fill the pool, some noise.
    calm_lo = req_backlog.size() + 600;
    calm_hi = calm_lo + 400;
    for (k = 0; k < RANDOM_WORDS; k++) begin
      pick = $urandom_range(99);
      op   = ($urandom_range(1) == 1) ? MODE_P : MODE_V;
      if (pick < 22 || gen_live == 0) begin
        push_word(MODE_CREATE, create_value());
      end else if (pick < 57) begin
        push_word(MODE_P, pick_live_id());
      end else if (pick < 92) begin
        push_word(MODE_V, pick_live_id());
      end else begin
        case ($urandom_range(3))
          0: push_word(op, -int'($urandom_range(32768, 1)));
          1: push_word(op, $urandom_range(32767, NUM_SEM));
          2: begin
            if (gen_live < NUM_SEM) push_word(op, $urandom_range(NUM_SEM - 1, gen_live));
            else push_word(op, $urandom_range(32767, NUM_SEM));
          end
          default: push_word(MODE_UNUSED, $urandom_range(65535));
        endcase
      end
    end

    // Make sure the pool ends up full, then hit it with more creates and traffic.
    while (gen_live < NUM_SEM) push_word(MODE_CREATE, $urandom_range(3));
    push_word(MODE_CREATE, 7);
    push_word(MODE_CREATE, 0);
    for (k = 0; k < 8; k++) push_word(($urandom_range(1) == 1) ? MODE_P : MODE_V, pick_live_id());
    push_word(MODE_CREATE, 32767);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all words sent, all results back, then let any stray word surface.
    while (req_backlog.size() != 0 || drv_valid) @(posedge clk);
    while (owed_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    faults += owed_outcomes.size();

    $display("Ran %0d request words: %0d creates granted, %0d P blocked, %0d woken.",
             words_sent, created_total, blocked_total, woken_total);
    $display("%0d requests rejected; saturation held %0d times on counts, %0d on waiters.",
             rejected_total, count_pinned, waiters_pinned);
    if (faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches.", faults);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/csp_pkg.sv
rtl/csp_if.sv
rtl/csp_ram.sv
rtl/csp_scan.sv
rtl/counting_semaphore_pool.sv
rtl/csp_chk.sv
verif/tb_counting_semaphore_pool.sv
